// ----- hw/rtl/uri_percent_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// uri_percent_decoder assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_DECODER_ASSERT_SVH
`define URI_PERCENT_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("upd assertion failed");
`define UPD_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("upd forbidden condition seen");
`else
`define UPD_ASSERT(lbl, prop)
`define UPD_ASSERT_NEVER(lbl, prop)
`endif
`endif

// ----- hw/rtl/upd_pkg.sv -----
// ----------------------------------------------------------------------------
// upd_pkg
// shared types and constants of the uri percent decoder
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned QueueDepth = 4;

  // decode phase of the front end
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HEX1  = 3'd1,
    PH_HEX2  = 3'd2,
    PH_CPCT  = 3'd3,
    PH_CHEX1 = 3'd4,
    PH_CHEX2 = 3'd5
  } upd_phase_e;

  // register indexes
  typedef enum logic {
    REG_KEEP_RESERVED = 1'b0
  } upd_reg_e;

  // one queued group of results, bytes[7:0] goes out first
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  last_idx;
    logic        err;
    logic        done;
  } upd_entry_t;

endpackage

// ----- hw/rtl/upd_front.sv -----
// ----------------------------------------------------------------------------
// upd_front
// escape parser: classifies each byte and queues the results it causes
// ----------------------------------------------------------------------------
`include "uri_percent_decoder_assert.svh"

module upd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                eos_i,
  input  logic                keep_reserved_i,
  output logic                push_o,
  output upd_pkg::upd_entry_t entry_o
);

  localparam logic [7:0] Percent = 8'h25;

  upd_pkg::upd_phase_e phase_q, phase_d;
  logic [3:0]  high_nib_q, high_nib_d;
  logic [7:0]  first_hex_q, first_hex_d;
  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic        dropping_q, dropping_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  dval;
  logic [20:0] acc_nxt;
  logic [1:0]  rem_nxt;
  logic        err;
  logic        bad_cp;
  logic [20:0] cp;

  function automatic logic is_reserved(input logic [7:0] v);
    logic r;
    r = (v == 8'h23) || (v == 8'h24) || (v == 8'h26) || (v == 8'h2B) ||
        (v == 8'h2C) || (v == 8'h2F) || (v == 8'h3A) || (v == 8'h3B) ||
        (v == 8'h3D) || (v == 8'h3F) || (v == 8'h40);
    return r;
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h41 && in_byte_i <= 8'h46) ||
                 (in_byte_i >= 8'h61 && in_byte_i <= 8'h66)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign dval    = {high_nib_q, hex_val};
  assign acc_nxt = {acc_q[14:0], dval[5:0]};
  assign rem_nxt = rem_q - 2'd1;

  // code point checks on the completed sequence
  always_comb begin
    cp     = acc_nxt;
    bad_cp = 1'b0;
    if (seq_len_q == 3'd2) begin
      cp     = {10'd0, acc_nxt[10:0]};
      bad_cp = (cp <= 21'h7F);
    end else if (seq_len_q == 3'd3) begin
      cp     = {5'd0, acc_nxt[15:0]};
      bad_cp = (cp <= 21'h7FF) || (cp >= 21'hD800 && cp <= 21'hDFFF);
    end else begin
      bad_cp = (cp <= 21'hFFFF) || (cp >= 21'h110000);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    high_nib_d  = high_nib_q;
    first_hex_d = first_hex_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    seq_len_d   = seq_len_q;
    dropping_d  = dropping_q;
    err         = 1'b0;
    push_o      = 1'b0;
    entry_o     = '{bytes: 32'd0, last_idx: 2'd0, err: 1'b0, done: eos_i};

    if (accept_i) begin
      if (dropping_q) begin
        if (eos_i) begin
          dropping_d = 1'b0;
        end
      end else begin
        unique case (phase_q)
          upd_pkg::PH_IDLE: begin
            if (in_byte_i == Percent) begin
              phase_d = upd_pkg::PH_HEX1;
            end else begin
              push_o        = 1'b1;
              entry_o.bytes = {24'd0, in_byte_i};
            end
          end
          upd_pkg::PH_HEX1: begin
            if (!hex_ok) begin
              err = 1'b1;
            end else begin
              high_nib_d  = hex_val;
              first_hex_d = in_byte_i;
              phase_d     = upd_pkg::PH_HEX2;
            end
          end
          upd_pkg::PH_HEX2: begin
            if (!hex_ok) begin
              err = 1'b1;
            end else if (!dval[7]) begin
              push_o  = 1'b1;
              phase_d = upd_pkg::PH_IDLE;
              if (keep_reserved_i && is_reserved(dval)) begin
                entry_o.bytes    = {8'd0, in_byte_i, first_hex_q, Percent};
                entry_o.last_idx = 2'd2;
              end else begin
                entry_o.bytes = {24'd0, dval};
              end
            end else begin
              priority if (dval[7:5] == 3'b110) begin
                seq_len_d = 3'd2;
                rem_d     = 2'd1;
              end else if (dval[7:4] == 4'b1110) begin
                seq_len_d = 3'd3;
                rem_d     = 2'd2;
              end else if (dval[7:3] == 5'b11110) begin
                seq_len_d = 3'd4;
                rem_d     = 2'd3;
              end else begin
                err = 1'b1;
              end
              if (!err) begin
                acc_d   = {13'd0, dval};
                phase_d = upd_pkg::PH_CPCT;
              end
            end
          end
          upd_pkg::PH_CPCT: begin
            if (in_byte_i != Percent) begin
              err = 1'b1;
            end else begin
              phase_d = upd_pkg::PH_CHEX1;
            end
          end
          upd_pkg::PH_CHEX1: begin
            if (!hex_ok) begin
              err = 1'b1;
            end else begin
              high_nib_d = hex_val;
              phase_d    = upd_pkg::PH_CHEX2;
            end
          end
          upd_pkg::PH_CHEX2: begin
            if (!hex_ok || dval[7:6] != 2'b10) begin
              err = 1'b1;
            end else begin
              acc_d = acc_nxt;
              rem_d = rem_nxt;
              if (rem_nxt == 2'd0) begin
                if (bad_cp) begin
                  err = 1'b1;
                end else begin
                  phase_d = upd_pkg::PH_IDLE;
                  push_o  = 1'b1;
                  if (seq_len_q == 3'd2) begin
                    entry_o.bytes    = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
                    entry_o.last_idx = 2'd1;
                  end else if (seq_len_q == 3'd3) begin
                    entry_o.bytes    = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6],
                                        4'b1110, cp[15:12]};
                    entry_o.last_idx = 2'd2;
                  end else begin
                    entry_o.bytes    = {2'b10, cp[5:0], 2'b10, cp[11:6],
                                        2'b10, cp[17:12], 5'b11110, cp[20:18]};
                    entry_o.last_idx = 2'd3;
                  end
                end
              end else begin
                phase_d = upd_pkg::PH_CPCT;
              end
            end
          end
          default: err = 1'b1;
        endcase

        if (!err && eos_i && phase_d != upd_pkg::PH_IDLE) begin
          err = 1'b1;
        end

        if (err) begin
          push_o     = 1'b1;
          entry_o    = '{bytes: 32'd0, last_idx: 2'd0, err: 1'b1, done: eos_i};
          dropping_d = !eos_i;
        end
      end

      if (err || eos_i) begin
        phase_d     = upd_pkg::PH_IDLE;
        high_nib_d  = 4'd0;
        first_hex_d = 8'd0;
        acc_d       = 21'd0;
        rem_d       = 2'd0;
        seq_len_d   = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= upd_pkg::PH_IDLE;
      high_nib_q  <= 4'd0;
      first_hex_q <= 8'd0;
      acc_q       <= 21'd0;
      rem_q       <= 2'd0;
      seq_len_q   <= 3'd0;
      dropping_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      high_nib_q  <= high_nib_d;
      first_hex_q <= first_hex_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      seq_len_q   <= seq_len_d;
      dropping_q  <= dropping_d;
    end
  end

  `UPD_ASSERT(a_drop_idle, dropping_q |-> phase_q == upd_pkg::PH_IDLE)
  `UPD_ASSERT(a_eos_clears, accept_i && eos_i |=> !dropping_q && phase_q == upd_pkg::PH_IDLE)

endmodule

// ----- hw/rtl/upd_queue.sv -----
// ----------------------------------------------------------------------------
// upd_queue
// small register queue of result groups between parser and emitter
// ----------------------------------------------------------------------------
`include "uri_percent_decoder_assert.svh"

module upd_queue #(
  parameter int unsigned DEPTH = upd_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  upd_pkg::upd_entry_t entry_i,
  input  logic                pop_i,
  output upd_pkg::upd_entry_t head_o,
  output logic                not_empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  upd_pkg::upd_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign not_empty_o = (count_q != '0);
  assign full_o      = (count_q == CntW'(DEPTH));
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `UPD_ASSERT_NEVER(a_overflow, push_i && full_o && !pop_i)
  `UPD_ASSERT_NEVER(a_underflow, pop_i && !not_empty_o)

endmodule

// ----- hw/rtl/upd_back.sv -----
// ----------------------------------------------------------------------------
// upd_back
// result emitter: sends queued groups one byte per transfer
// ----------------------------------------------------------------------------
`include "uri_percent_decoder_assert.svh"

module upd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upd_pkg::upd_entry_t head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output logic                m_axis_tlast,
  output logic [1:0]          m_axis_tuser
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [1:0] user_q, user_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       last_byte;

  assign load      = !valid_q || m_axis_tready;
  assign last_byte = (idx_q == head_i.last_idx);

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    user_d  = user_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        unique case (idx_q)
          2'd0:    byte_d = head_i.bytes[7:0];
          2'd1:    byte_d = head_i.bytes[15:8];
          2'd2:    byte_d = head_i.bytes[23:16];
          default: byte_d = head_i.bytes[31:24];
        endcase
        last_d = last_byte;
        user_d = {head_i.done, head_i.err};
        pop_o  = last_byte;
        idx_d  = last_byte ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = byte_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = user_q;

  `UPD_ASSERT(a_err_single, valid_q && user_q[0] |-> last_q && byte_q == 8'd0)
  `UPD_ASSERT(a_idx_reset, $past(pop_o) |-> idx_q == 2'd0)

endmodule

// ----- hw/rtl/uri_percent_decoder.sv -----
// ----------------------------------------------------------------------------
// uri_percent_decoder
// streaming percent-escape decoder for uri strings with utf-8 checking
// ----------------------------------------------------------------------------
// Input bytes are taken one per cycle whenever the result queue has room; an
// escape is parsed one character per transfer and its decoded bytes, or one
// error result, are queued as a group. The emitter sends one result byte per
// cycle when m_axis_tready allows, from a registered output, so a byte that
// yields n results holds the output side for n result bytes (up to four for
// a utf-8 sequence or three for a kept reserved escape) while input keeps
// flowing into the queue of QUEUE_DEPTH groups. keep_reserved resets to 1
// and is written at byte address 0.
// ----------------------------------------------------------------------------
module uri_percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = upd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [7:0] in_byte; tlast: end_of_string
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  // tdata: [7:0] out_byte; tlast: run_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // tuser: [0] uri_error, [1] string_done
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                keep_reserved_q;
  logic                accept;
  logic                push;
  logic                pop;
  logic                full;
  logic                not_empty;
  upd_pkg::upd_entry_t entry;
  upd_pkg::upd_entry_t head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == upd_pkg::REG_KEEP_RESERVED) ? {31'd0, keep_reserved_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_reserved_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == upd_pkg::REG_KEEP_RESERVED) begin
      keep_reserved_q <= pwdata[0];
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  upd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (s_axis_tdata),
    .eos_i           (s_axis_tlast),
    .keep_reserved_i (keep_reserved_q),
    .push_o          (push),
    .entry_o         (entry)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  upd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (not_empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
